FILE: hw/rtl/jsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

	// Work for the result side: one to three results that one input byte causes.
	typedef struct packed {
		logic [1:0]  last_idx;
		logic        char_valid;
		logic        finished;
		logic        failed;
		logic [15:0] first_len;
		logic [7:0]  byte0;
		logic [7:0]  byte1;
		logic [7:0]  byte2;
	} jsu_entry_t;

	localparam int unsigned ENTRY_BITS = $bits(jsu_entry_t);

	localparam logic [15:0] MAX_BYTES_RESET = 16'd1024;

endpackage

`default_nettype wire

FILE: hw/rtl/jsu_front.sv
`timescale 1ns / 1ps
`default_nettype none

module jsu_front #(
	parameter int LENGTH_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [15:0]         max_string_bytes,
	input  wire logic                in_valid,
	input  wire logic                in_ready,
	input  wire logic [7:0]          data_byte,
	input  wire logic                buffer_end,
	output logic                     push,
	output jsu_pkg::jsu_entry_t      entry
);

	localparam int W = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 2;
	localparam logic [W-1:0] CAP_W = (W'(1) << LENGTH_BITS) - W'(1);

	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_SLASH     = 8'h2f;
	localparam logic [7:0] CH_N         = 8'h6e;
	localparam logic [7:0] CH_R         = 8'h72;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_B         = 8'h62;
	localparam logic [7:0] CH_F         = 8'h66;
	localparam logic [7:0] CH_U         = 8'h75;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_BODY,
		MODE_ESC,
		MODE_HEX1,
		MODE_HEX2,
		MODE_HEX3,
		MODE_HEX4
	} mode_t;

	mode_t                  mode_q, mode_d;
	logic [15:0]            acc_q, acc_d;
	logic [LENGTH_BITS-1:0] count_q, count_d;

	logic [W-1:0] cnt_w, cnt1_w, cnt2_w, cnt3_w, max_w, lim_w;
	logic         hex_ok;
	logic [3:0]   hex_val;
	logic [15:0]  cp;

	assign cnt_w  = W'(count_q);
	assign cnt1_w = cnt_w + W'(1);
	assign cnt2_w = cnt_w + W'(2);
	assign cnt3_w = cnt_w + W'(3);
	assign max_w  = W'(max_string_bytes);
	assign lim_w  = (max_w > CAP_W) ? CAP_W : max_w;
	assign cp     = {acc_q[11:0], hex_val};

	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
			hex_val = 4'(data_byte - 8'h30);
		end else if (data_byte >= 8'h61 && data_byte <= 8'h66) begin
			hex_val = 4'(data_byte - 8'h57);
		end else if (data_byte >= 8'h41 && data_byte <= 8'h46) begin
			hex_val = 4'(data_byte - 8'h37);
		end else begin
			hex_ok = 1'b0;
		end
	end

	always_comb begin
		logic do_fail;
		logic do_emit;
		logic [7:0] emit_byte;
		do_fail   = 1'b0;
		do_emit   = 1'b0;
		emit_byte = 8'd0;
		mode_d    = mode_q;
		acc_d     = acc_q;
		count_d   = count_q;
		entry     = '0;
		entry.first_len = cnt_w[15:0];
		unique case (mode_q) inside
			MODE_BODY: begin
				if (data_byte == CH_QUOTE) begin
					entry.finished = 1'b1;
					mode_d  = MODE_IDLE;
					acc_d   = '0;
					count_d = '0;
				end else if (cnt_w >= lim_w || buffer_end) begin
					do_fail = 1'b1;
				end else if (data_byte == CH_BACKSLASH) begin
					mode_d = MODE_ESC;
				end else begin
					do_emit   = 1'b1;
					emit_byte = data_byte;
				end
			end
			MODE_ESC: begin
				if (buffer_end) begin
					do_fail = 1'b1;
				end else begin
					case (data_byte) inside
						CH_N: begin
							do_emit   = 1'b1;
							emit_byte = 8'd10;
						end
						CH_R: begin
							do_emit   = 1'b1;
							emit_byte = 8'd13;
						end
						CH_T: begin
							do_emit   = 1'b1;
							emit_byte = 8'd9;
						end
						CH_B: begin
							do_emit   = 1'b1;
							emit_byte = 8'd8;
						end
						CH_F: begin
							do_emit   = 1'b1;
							emit_byte = 8'd12;
						end
						CH_QUOTE, CH_SLASH, CH_BACKSLASH: begin
							do_emit   = 1'b1;
							emit_byte = data_byte;
						end
						CH_U: begin
							acc_d  = '0;
							mode_d = MODE_HEX1;
						end
						default: do_fail = 1'b1;
					endcase
				end
			end
			MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
				if (!hex_ok || buffer_end) begin
					do_fail = 1'b1;
				end else begin
					acc_d  = cp;
					mode_d = mode_t'(mode_q + 3'd1);
				end
			end
			MODE_HEX4: begin
				acc_d = cp;
				if (!hex_ok || buffer_end) begin
					do_fail = 1'b1;
				end else if (cp[15:7] == '0) begin
					do_emit   = 1'b1;
					emit_byte = cp[7:0];
				end else if (cp[15:11] == '0) begin
					if (cnt1_w >= lim_w) begin
						do_fail = 1'b1;
					end else begin
						entry.char_valid = 1'b1;
						entry.last_idx   = 2'd1;
						entry.first_len  = cnt1_w[15:0];
						entry.byte0      = {3'b110, cp[10:6]};
						entry.byte1      = {2'b10, cp[5:0]};
						count_d = cnt2_w[LENGTH_BITS-1:0];
						mode_d  = MODE_BODY;
					end
				end else if (cp[15:11] == 5'b11011) begin
					do_fail = 1'b1;
				end else begin
					if (cnt2_w >= lim_w) begin
						do_fail = 1'b1;
					end else begin
						entry.char_valid = 1'b1;
						entry.last_idx   = 2'd2;
						entry.first_len  = cnt1_w[15:0];
						entry.byte0      = {4'b1110, cp[15:12]};
						entry.byte1      = {2'b10, cp[11:6]};
						entry.byte2      = {2'b10, cp[5:0]};
						count_d = cnt3_w[LENGTH_BITS-1:0];
						mode_d  = MODE_BODY;
					end
				end
			end
			default: begin
				if (data_byte != CH_QUOTE || buffer_end) begin
					do_fail = 1'b1;
				end else begin
					mode_d  = MODE_BODY;
					acc_d   = '0;
					count_d = '0;
					entry.first_len = '0;
				end
			end
		endcase
		if (do_emit) begin
			entry.char_valid = 1'b1;
			entry.byte0      = emit_byte;
			entry.first_len  = cnt1_w[15:0];
			count_d = cnt1_w[LENGTH_BITS-1:0];
			mode_d  = MODE_BODY;
		end
		if (do_fail) begin
			entry        = '0;
			entry.failed = 1'b1;
			entry.first_len = cnt_w[15:0];
			mode_d  = MODE_IDLE;
			acc_d   = '0;
			count_d = '0;
		end
	end

	assign push = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			acc_q   <= '0;
			count_q <= '0;
		end else if (push) begin
			mode_q  <= mode_d;
			acc_q   <= acc_d;
			count_q <= count_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDLE) |-> (count_q == '0))
		else $error("count is nonzero outside a string");

endmodule

`default_nettype wire

FILE: hw/rtl/jsu_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module jsu_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  full,
	output logic                  empty
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0]  mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_BITS:0]   count_q;

	assign full    = (count_q == (PTR_BITS + 1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
			end
			count_q <= count_q + (PTR_BITS + 1)'(push) - (PTR_BITS + 1)'(pop);
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/jsu_back.sv
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire jsu_pkg::jsu_entry_t entry,
	input  wire logic                empty,
	output logic                     pop,
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic [23:0]              m_axis_tdata,
	output logic [2:0]               m_axis_tuser,
	output logic                     m_axis_tlast
);

	logic       out_valid_q;
	logic [1:0] idx_q;
	logic       advance, load, last_res;
	logic [7:0] sel_byte;

	assign advance  = !out_valid_q || m_axis_tready;
	assign load     = advance && !empty;
	assign last_res = (idx_q == entry.last_idx);
	assign pop      = load && last_res;

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = entry.byte0;
			2'd1:    sel_byte = entry.byte1;
			default: sel_byte = entry.byte2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (advance) begin
			out_valid_q <= !empty;
			if (load) begin
				idx_q <= last_res ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_axis_tdata <= {entry.first_len + 16'(idx_q), sel_byte};
			m_axis_tuser <= {entry.failed, entry.finished, entry.char_valid};
			m_axis_tlast <= last_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd3)
		else $error("result index out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 2'd0) |-> !empty)
		else $error("entry left the queue before all its results were sent");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (m_axis_tuser[1] || m_axis_tuser[2]))
			|-> (m_axis_tlast && !m_axis_tuser[0]))
		else $error("end of string result carries a byte or is not last");

endmodule

`default_nettype wire

FILE: hw/rtl/json_string_unescaper_utf8_core.sv
// Flow: a byte transferred on the slave side is written into the queue; its first
// result is then registered at the master side, and further results of the same
// byte follow one per cycle while m_axis_tready is high. Throughput: one byte per
// cycle while the queue is not full; a UTF-8 sequence of two or three bytes holds
// its queue entry until its last result is sent. Reset: arst_n clears the parser
// to wait for an opening quote, empties the queue and sets max_string_bytes to 1024.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescaper_utf8_core #(
	parameter int LENGTH_BITS = 16,
	parameter int FIFO_DEPTH  = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // data_byte
	input  wire logic        s_axis_tlast,  // buffer_end
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // char_byte, string_length
	output logic [2:0]       m_axis_tuser,  // char_valid, finished, failed
	output logic             m_axis_tlast   // last_of_run
);

	logic [15:0] max_bytes_q;
	logic        push, pop, full, empty;
	logic [jsu_pkg::ENTRY_BITS-1:0] wr_bits, rd_bits;
	jsu_pkg::jsu_entry_t wr_entry, rd_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= jsu_pkg::MAX_BYTES_RESET;
		end else if (cfg_we) begin
			max_bytes_q <= cfg_wdata;
		end
	end

	assign s_axis_tready = !full;

	jsu_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.max_string_bytes(max_bytes_q),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.data_byte       (s_axis_tdata),
		.buffer_end      (s_axis_tlast),
		.push            (push),
		.entry           (wr_entry)
	);

	assign wr_bits  = wr_entry;
	assign rd_entry = jsu_pkg::jsu_entry_t'(rd_bits);

	jsu_fifo #(
		.WIDTH(jsu_pkg::ENTRY_BITS),
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(wr_bits),
		.pop    (pop),
		.rd_data(rd_bits),
		.full   (full),
		.empty  (empty)
	);

	jsu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.entry        (rd_entry),
		.empty        (empty),
		.pop          (pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

`default_nettype wire

FILE: tb/sv/json_string_unescaper_utf8_core_tb.sv
`timescale 1ns / 1ps

module json_string_unescaper_utf8_core_tb;

	localparam logic [7:0] QUOTE  = 8'h22;
	localparam logic [7:0] BSLASH = 8'h5c;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 40;

	typedef enum logic [2:0] {
		PM_IDLE, PM_BODY, PM_ESC, PM_HEX1, PM_HEX2, PM_HEX3, PM_HEX4
	} parse_mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eob;
	} raw_byte_t;

	typedef struct packed {
		logic        char_valid;
		logic [7:0]  char_byte;
		logic        finished;
		logic        failed;
		logic [15:0] len;
		logic        last;
	} decoded_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	raw_byte_t   raw_q[$];
	decoded_t    decoded_q[$];

	parse_mode_t mode = PM_IDLE;
	logic [15:0] hex_acc = '0;
	int unsigned out_count = 0;
	logic [15:0] max_bytes = 16'd1024;

	int send_idle = 0;
	int recv_stall = 0;
	int errors = 0;
	int phase_items = 0;
	int quiet_cycles = 0;

	always #4 clk = ~clk;

	json_string_unescaper_utf8_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tlast  (s_tlast),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser),
		.m_axis_tlast  (m_tlast)
	);

	task automatic unescape_byte(input logic [7:0] c, input logic eob);
		decoded_t    r [3];
		int          n;
		logic        bad;
		logic        emit;
		logic [7:0]  ch;
		logic [3:0]  nib;
		logic [15:0] cp;
		int unsigned lim;
		n = 1;
		bad = 1'b0;
		emit = 1'b0;
		ch = '0;
		nib = '0;
		lim = max_bytes;
		for (int k = 0; k < 3; k++) r[k] = '0;
		case (mode)
			PM_BODY: begin
				if (c == QUOTE) begin
					r[0].finished = 1'b1;
					r[0].len = out_count[15:0];
					mode = PM_IDLE;
					hex_acc = '0;
					out_count = 0;
				end else if (out_count >= lim || eob) begin
					bad = 1'b1;
				end else if (c == BSLASH) begin
					mode = PM_ESC;
					r[0].len = out_count[15:0];
				end else begin
					emit = 1'b1;
					ch = c;
				end
			end
			PM_ESC: begin
				if (eob) begin
					bad = 1'b1;
				end else begin
					emit = 1'b1;
					case (c)
						"n": ch = 8'd10;
						"r": ch = 8'd13;
						"t": ch = 8'd9;
						"b": ch = 8'd8;
						"f": ch = 8'd12;
						QUOTE, "/", BSLASH: ch = c;
						"u": begin
							emit = 1'b0;
							hex_acc = '0;
							mode = PM_HEX1;
							r[0].len = out_count[15:0];
						end
						default: begin
							emit = 1'b0;
							bad = 1'b1;
						end
					endcase
				end
			end
			PM_HEX1, PM_HEX2, PM_HEX3, PM_HEX4: begin
				if (c inside {["0":"9"]}) nib = 4'(c - "0");
				else if (c inside {["a":"f"]}) nib = 4'(c - "a" + 10);
				else if (c inside {["A":"F"]}) nib = 4'(c - "A" + 10);
				if (!(c inside {["0":"9"], ["a":"f"], ["A":"F"]}) || eob) begin
					bad = 1'b1;
				end else begin
					hex_acc = {hex_acc[11:0], nib};
					if (mode != PM_HEX4) begin
						mode = parse_mode_t'(mode + 3'd1);
						r[0].len = out_count[15:0];
					end else begin
						cp = hex_acc;
						if (cp < 16'h80) begin
							emit = 1'b1;
							ch = cp[7:0];
						end else if (cp < 16'h800) begin
							if (out_count + 1 >= lim) begin
								bad = 1'b1;
							end else begin
								r[0] = '{1'b1, {3'b110, cp[10:6]}, 1'b0, 1'b0,
									16'(out_count + 1), 1'b0};
								r[1] = '{1'b1, {2'b10, cp[5:0]}, 1'b0, 1'b0,
									16'(out_count + 2), 1'b0};
								n = 2;
							end
						end else if (cp inside {[16'hd800:16'hdfff]}) begin
							bad = 1'b1;
						end else if (out_count + 2 >= lim) begin
							bad = 1'b1;
						end else begin
							r[0] = '{1'b1, {4'b1110, cp[15:12]}, 1'b0, 1'b0,
								16'(out_count + 1), 1'b0};
							r[1] = '{1'b1, {2'b10, cp[11:6]}, 1'b0, 1'b0,
								16'(out_count + 2), 1'b0};
							r[2] = '{1'b1, {2'b10, cp[5:0]}, 1'b0, 1'b0,
								16'(out_count + 3), 1'b0};
							n = 3;
						end
						if (n > 1) begin
							out_count += n;
							mode = PM_BODY;
						end
					end
				end
			end
			default: begin
				if (c != QUOTE || eob) begin
					bad = 1'b1;
				end else begin
					mode = PM_BODY;
					hex_acc = '0;
					out_count = 0;
				end
			end
		endcase
		if (emit) begin
			out_count++;
			r[0] = '{1'b1, ch, 1'b0, 1'b0, out_count[15:0], 1'b0};
			mode = PM_BODY;
		end
		if (bad) begin
			r[0] = '{1'b0, 8'd0, 1'b0, 1'b1, out_count[15:0], 1'b0};
			n = 1;
			mode = PM_IDLE;
			hex_acc = '0;
			out_count = 0;
		end
		r[n - 1].last = 1'b1;
		for (int k = 0; k < n; k++) decoded_q.push_back(r[k]);
	endtask

	always @(posedge clk or negedge arst_n) begin : sender
		raw_byte_t nx;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) unescape_byte(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (raw_q.size() != 0 && $urandom_range(99) >= send_idle) begin
					nx = raw_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= nx.data;
					s_tlast <= nx.eob;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : receiver
		decoded_t got;
		decoded_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = '{m_tuser[0], m_tdata[7:0], m_tuser[1], m_tuser[2],
					m_tdata[23:8], m_tlast};
				if (decoded_q.size() == 0) begin
					errors++;
					$display("%0t: expected none, actual v=%0b b=%02h fin=%0b fail=%0b len=%0d last=%0b",
						$time, got.char_valid, got.char_byte, got.finished,
						got.failed, got.len, got.last);
				end else begin
					want = decoded_q.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: expected v=%0b b=%02h fin=%0b fail=%0b len=%0d last=%0b",
							$time, want.char_valid, want.char_byte, want.finished,
							want.failed, want.len, want.last);
						$display("%0t: actual   v=%0b b=%02h fin=%0b fail=%0b len=%0d last=%0b",
							$time, got.char_valid, got.char_byte, got.finished,
							got.failed, got.len, got.last);
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic push_byte(input logic [7:0] c, input logic eob);
		raw_q.push_back('{c, eob});
		phase_items++;
	endtask

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		if (v < 10) return 8'("0" + v);
		return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
	endfunction

	task automatic push_unicode(input logic [15:0] cp);
		push_byte(BSLASH, 1'b0);
		push_byte("u", 1'b0);
		for (int k = 3; k >= 0; k--) push_byte(hex_digit(cp[4 * k +: 4]), 1'b0);
	endtask

	task automatic push_string();
		int          kind;
		int          count;
		int          break_at;
		int          sel;
		int          digits;
		logic [7:0]  b;
		logic [15:0] cp;
		logic [7:0]  escapes [8];
		escapes = '{"n", "r", "t", "b", "f", QUOTE, "/", BSLASH};
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			count = $urandom_range(1, 4);
			for (int k = 0; k < count; k++)
				push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			return;
		end
		push_byte(QUOTE, 1'b0);
		count = $urandom_range(0, 12);
		break_at = (kind < 24) ? $urandom_range(0, count) : -1;
		for (int e = 0; e <= count; e++) begin
			if (e == break_at) begin
				sel = $urandom_range(0, 3);
				digits = $urandom_range(0, 3);
				case (sel)
					0: begin
						push_byte(BSLASH, 1'b0);
						do b = 8'($urandom_range(0, 255));
						while (b inside {"n", "r", "t", "b", "f", QUOTE, "/", BSLASH, "u"});
						push_byte(b, 1'b0);
					end
					1, 3: begin
						push_byte(BSLASH, 1'b0);
						push_byte("u", 1'b0);
						for (int k = 0; k < digits; k++)
							push_byte(hex_digit(4'($urandom_range(0, 15))), 1'b0);
						if (sel == 3) begin
							push_byte(hex_digit(4'($urandom_range(0, 15))), 1'b1);
						end else begin
							do b = 8'($urandom_range(0, 255));
							while (b inside {["0":"9"], ["a":"f"], ["A":"F"]});
							push_byte(b, 1'b0);
						end
					end
					default: push_byte(8'($urandom_range(0, 255)), 1'b1);
				endcase
			end
			if (e == count) break;
			sel = $urandom_range(0, 9);
			if (sel < 4) begin
				do b = 8'($urandom_range(0, 255));
				while (b == QUOTE || b == BSLASH);
				push_byte(b, 1'b0);
			end else if (sel < 6) begin
				push_byte(BSLASH, 1'b0);
				push_byte(escapes[$urandom_range(0, 7)], 1'b0);
			end else begin
				sel = $urandom_range(0, 9);
				if (sel < 3) begin
					cp = 16'($urandom_range(0, 16'h7f));
				end else if (sel < 6) begin
					cp = 16'($urandom_range(16'h80, 16'h7ff));
				end else if (sel < 9) begin
					cp = 16'($urandom_range(16'h800, 16'hffff));
					if (cp inside {[16'hd800:16'hdfff]}) cp ^= 16'h2000;
				end else begin
					cp = 16'($urandom_range(16'hd800, 16'hdfff));
				end
				push_unicode(cp);
			end
		end
		push_byte(QUOTE, 1'($urandom_range(0, 1)));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (raw_q.size() != 0 || s_tvalid || decoded_q.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_max_bytes(input logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		max_bytes = v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		logic [15:0] limits [8];
		limits = '{16'd0, 16'd65535, 16'd1, 16'd2, 16'd3, 16'd1024, 16'd4, 16'd0};
		limits[7] = 16'($urandom_range(5, 40));
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_byte("x", 1'b0);
		push_byte(QUOTE, 1'b1);
		push_byte(QUOTE, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(BSLASH, 1'b0);
		push_byte(QUOTE, 1'b0);
		push_unicode(16'h07ff);
		push_unicode(16'hd800);
		push_byte(QUOTE, 1'b0);
		push_byte("a", 1'b1);
		push_byte(QUOTE, 1'b0);
		push_byte(QUOTE, 1'b1);
		wait_idle();

		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 75; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 75; end
				default: begin send_idle = 38; recv_stall = 38; end
			endcase
			write_max_bytes(limits[p]);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) push_string();
			wait_idle();
		end

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_front.sv
hw/rtl/jsu_fifo.sv
hw/rtl/jsu_back.sv
hw/rtl/json_string_unescaper_utf8_core.sv
tb/sv/json_string_unescaper_utf8_core_tb.sv
